// ===== src/earliest_deadline_timer_scheduler_defines.svh =====
// Assertion macros for the earliest deadline timer scheduler.
// Each macro expects clk and rst in scope.
`ifndef EARLIEST_DEADLINE_TIMER_SCHEDULER_DEFINES_SVH
`define EARLIEST_DEADLINE_TIMER_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define EDTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EDTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EDTS_ASSERT_IMP(label, ante, cons)
`define EDTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/edts_pkg.sv =====
package edts_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int TIME_W    = 32;
  localparam int HANDLE_W  = 8;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_ARM      = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_MOVE,
    S_DUE,
    S_SCHED,
    S_SCAN,
    S_CLAMP,
    S_BUMP,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic    handle_en;
    logic    deadline_en;
    logic    active_en;
    idx_t    idx;
    handle_t handle;
    time_t   deadline;
    logic    active;
    logic    clr_en;
    idx_t    clr_idx;
  } tbl_wr_t;

  typedef struct packed {
    handle_t handle;
    time_t   deadline;
    logic    active;
  } slot_t;

  typedef struct packed {
    time_t diff;
    logic  neg;
    logic  zero;
  } sub_res_t;

endpackage

// ===== src/earliest_deadline_timer_scheduler.sv =====
// Arm, add, remove and dispatch each step through the table entries, and each can stall on out_ready.
// Throughput: one request at a time; a single shared 32-bit subtractor and one
// table read port are stepped once per slot for the search, due scan and minimum scan.
// Reset: synchronous; clears the entry count, active bits, interrupt enable and
// output valid directly, with no clearing pass.
`include "earliest_deadline_timer_scheduler_defines.svh"

module earliest_deadline_timer_scheduler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              operation,
  input  edts_pkg::handle_t       event_id,
  input  edts_pkg::time_t         now,
  input  edts_pkg::time_t         deadline,
  input  logic                    active,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    kind,
  output edts_pkg::handle_t       fired_id,
  output edts_pkg::time_t         compare_value,
  output logic                    compare_written,
  output logic                    irq_enabled,
  output logic                    last
);
  import edts_pkg::*;

  state_t  state, state_next;
  op_t     op, op_next;
  handle_t id, id_next;
  time_t   now_r, now_r_next;
  time_t   dl_r, dl_r_next;
  logic    act_r, act_r_next;
  cnt_t    ix, ix_next;
  cnt_t    count, count_next;
  logic    irq_on, irq_on_next;
  logic    found, found_next;
  idx_t    fidx, fidx_next;
  logic    have_best, have_best_next;
  idx_t    best_idx, best_idx_next;
  time_t   best_dl, best_dl_next;
  time_t   cmp_r, cmp_r_next;
  logic    wr_r, wr_r_next;

  logic    out_valid_next;
  logic    kind_next;
  handle_t fired_id_next;
  time_t   compare_value_next;
  logic    compare_written_next;
  logic    irq_enabled_next;
  logic    last_next;

  logic     out_free;
  tbl_wr_t  tbl_wr;
  slot_t    rd;
  time_t    sub_a, sub_b;
  sub_res_t sub;
  cnt_t     last_ix;

  edts_slots u_slots (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (ix[IDX_W-1:0]),
    .wr     (tbl_wr),
    .rd     (rd)
  );

  edts_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign last_ix  = count - cnt_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      irq_on    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      irq_on    <= irq_on_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op              <= op_next;
    id              <= id_next;
    now_r           <= now_r_next;
    dl_r            <= dl_r_next;
    act_r           <= act_r_next;
    ix              <= ix_next;
    found           <= found_next;
    fidx            <= fidx_next;
    have_best       <= have_best_next;
    best_idx        <= best_idx_next;
    best_dl         <= best_dl_next;
    cmp_r           <= cmp_r_next;
    wr_r            <= wr_r_next;
    kind            <= kind_next;
    fired_id        <= fired_id_next;
    compare_value   <= compare_value_next;
    compare_written <= compare_written_next;
    irq_enabled     <= irq_enabled_next;
    last            <= last_next;
  end

  always_comb begin
    state_next           = state;
    op_next              = op;
    id_next              = id;
    now_r_next           = now_r;
    dl_r_next            = dl_r;
    act_r_next           = act_r;
    ix_next              = ix;
    count_next           = count;
    irq_on_next          = irq_on;
    found_next           = found;
    fidx_next            = fidx;
    have_best_next       = have_best;
    best_idx_next        = best_idx;
    best_dl_next         = best_dl;
    cmp_r_next           = cmp_r;
    wr_r_next            = wr_r;
    out_valid_next       = out_valid && !out_ready;
    kind_next            = kind;
    fired_id_next        = fired_id;
    compare_value_next   = compare_value;
    compare_written_next = compare_written;
    irq_enabled_next     = irq_enabled;
    last_next            = last;
    tbl_wr               = '0;
    sub_a                = now_r;
    sub_b                = rd.deadline;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next        = op_t'(operation);
          id_next        = event_id;
          now_r_next     = now;
          dl_r_next      = deadline;
          act_r_next     = active;
          ix_next        = '0;
          found_next     = 1'b0;
          have_best_next = 1'b0;
          cmp_r_next     = '0;
          wr_r_next      = 1'b0;
          if (op_t'(operation) == OP_ADD) begin
            irq_on_next = 1'b1;
          end
          state_next = (op_t'(operation) == OP_DISPATCH) ? S_DUE : S_FIND;
        end
      end

      S_FIND: begin
        if (ix == count) begin
          state_next = S_APPLY;
        end else if (rd.handle == id) begin
          found_next = 1'b1;
          fidx_next  = ix[IDX_W-1:0];
          state_next = S_APPLY;
        end else begin
          ix_next = ix + cnt_t'(1);
        end
      end

      S_APPLY: begin
        unique case (op)
          OP_ADD: begin
            if (!found && count < cnt_t'(MAX_SLOTS)) begin
              tbl_wr.handle_en   = 1'b1;
              tbl_wr.deadline_en = 1'b1;
              tbl_wr.active_en   = 1'b1;
              tbl_wr.idx         = count[IDX_W-1:0];
              tbl_wr.handle      = id;
              tbl_wr.deadline    = '0;
              tbl_wr.active      = 1'b0;
              count_next         = count + cnt_t'(1);
              state_next         = S_SCHED;
            end else begin
              state_next = S_STATUS;
            end
          end
          OP_REMOVE: begin
            if (found) begin
              ix_next    = last_ix;
              state_next = S_MOVE;
            end else begin
              state_next = S_SCHED;
            end
          end
          OP_ARM: begin
            if (found) begin
              tbl_wr.deadline_en = 1'b1;
              tbl_wr.active_en   = 1'b1;
              tbl_wr.idx         = fidx;
              tbl_wr.deadline    = dl_r;
              tbl_wr.active      = act_r;
            end
            state_next = S_STATUS;
          end
          default: begin
            state_next = S_STATUS;
          end
        endcase
      end

      S_MOVE: begin
        tbl_wr.handle_en   = 1'b1;
        tbl_wr.deadline_en = 1'b1;
        tbl_wr.active_en   = 1'b1;
        tbl_wr.idx         = fidx;
        tbl_wr.handle      = rd.handle;
        tbl_wr.deadline    = rd.deadline;
        tbl_wr.active      = rd.active;
        tbl_wr.clr_en      = 1'b1;
        tbl_wr.clr_idx     = ix[IDX_W-1:0];
        count_next         = last_ix;
        state_next         = S_SCHED;
      end

      S_DUE: begin
        sub_a = now_r;
        sub_b = rd.deadline;
        if (ix == count) begin
          state_next = S_SCHED;
        end else if (rd.active && !sub.neg) begin
          if (out_free) begin
            out_valid_next       = 1'b1;
            kind_next            = KIND_FIRED;
            fired_id_next        = rd.handle;
            compare_value_next   = '0;
            compare_written_next = 1'b0;
            irq_enabled_next     = irq_on;
            last_next            = 1'b0;
            ix_next              = ix + cnt_t'(1);
          end
        end else begin
          ix_next = ix + cnt_t'(1);
        end
      end

      S_SCHED: begin
        ix_next        = '0;
        have_best_next = 1'b0;
        if (count == '0) begin
          irq_on_next = 1'b0;
          state_next  = S_STATUS;
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        sub_a = rd.deadline;
        sub_b = best_dl;
        if (ix == count) begin
          state_next = have_best ? S_CLAMP : S_STATUS;
        end else begin
          if (rd.active && (!have_best || sub.neg)) begin
            have_best_next = 1'b1;
            best_idx_next  = ix[IDX_W-1:0];
            best_dl_next   = rd.deadline;
          end
          ix_next = ix + cnt_t'(1);
        end
      end

      S_CLAMP: begin
        sub_a = best_dl;
        sub_b = now_r;
        if (sub.zero || sub.neg) begin
          state_next = S_BUMP;
        end else begin
          cmp_r_next = best_dl;
          wr_r_next  = 1'b1;
          state_next = S_STATUS;
        end
      end

      S_BUMP: begin
        // now - (-1) gives now + 1
        sub_a              = now_r;
        sub_b              = '1;
        tbl_wr.deadline_en = 1'b1;
        tbl_wr.idx         = best_idx;
        tbl_wr.deadline    = sub.diff;
        cmp_r_next         = sub.diff;
        wr_r_next          = 1'b1;
        state_next         = S_STATUS;
      end

      S_STATUS: begin
        if (out_free) begin
          out_valid_next       = 1'b1;
          kind_next            = KIND_STATUS;
          fired_id_next        = '0;
          compare_value_next   = wr_r ? cmp_r : '0;
          compare_written_next = wr_r;
          irq_enabled_next     = irq_on;
          last_next            = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `EDTS_ASSERT_IMP(a_count_bound, 1'b1, count <= cnt_t'(MAX_SLOTS))
  `EDTS_ASSERT_IMP(a_irq_when_filled, count != '0, irq_on)
  `EDTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `EDTS_ASSERT_IMP(a_fired_no_compare, out_valid && !last,
                   !compare_written && compare_value == '0 && kind == KIND_FIRED)

endmodule

// ===== src/edts_sub.sv =====
module edts_sub (
  input  edts_pkg::time_t    a,
  input  edts_pkg::time_t    b,
  output edts_pkg::sub_res_t res
);
  import edts_pkg::*;

  time_t diff;

  assign diff     = a - b;
  assign res.diff = diff;
  assign res.neg  = diff[TIME_W-1];
  assign res.zero = (diff == '0);

endmodule

// ===== src/edts_slots.sv =====
module edts_slots (
  input  logic              clk,
  input  logic              rst,
  input  edts_pkg::idx_t    rd_idx,
  input  edts_pkg::tbl_wr_t wr,
  output edts_pkg::slot_t   rd
);
  import edts_pkg::*;

  handle_t              handle_mem   [MAX_SLOTS];
  time_t                deadline_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] active_bits, active_bits_next;

  always_ff @(posedge clk) begin
    if (wr.handle_en) begin
      handle_mem[wr.idx] <= wr.handle;
    end
    if (wr.deadline_en) begin
      deadline_mem[wr.idx] <= wr.deadline;
    end
  end

  // clear of the vacated slot wins over the move into it
  always_comb begin
    active_bits_next = active_bits;
    if (wr.active_en) begin
      active_bits_next[wr.idx] = wr.active;
    end
    if (wr.clr_en) begin
      active_bits_next[wr.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= '0;
    end else begin
      active_bits <= active_bits_next;
    end
  end

  assign rd.handle   = handle_mem[rd_idx];
  assign rd.deadline = deadline_mem[rd_idx];
  assign rd.active   = active_bits[rd_idx];

endmodule
